// ===== src/csts_pkg.sv =====
// shared types and constants of the cascade shot trigger sequencer
`default_nettype none

package csts_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;
   localparam int unsigned TIME_CFG_WIDTH  = 24;
   localparam int unsigned POS_WIDTH       = 32;
   localparam int unsigned OUT_COUNT_WIDTH = 32;
   localparam int unsigned KIND_WIDTH      = 2;
   localparam int unsigned REM_STEP_WIDTH  = $clog2(POS_WIDTH);

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DAQ_DELAY      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PULSE_WIDTH    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAM_EVERY      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BASELINE_SHOTS = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECORD_SHOTS   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CYCLE_SHOTS    = 3'd5;

   // item kinds
   localparam logic [KIND_WIDTH-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_STOP  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_START = 2'd2;

   localparam logic [3:0] BLOCK_MARK = 4'b1000;

   typedef struct packed {
      logic [TIME_CFG_WIDTH-1:0] daq_delay;
      logic [TIME_CFG_WIDTH-1:0] pulse_width;
      logic [POS_WIDTH-1:0]      period;
      logic [POS_WIDTH-1:0]      baseline_shots;
      logic [POS_WIDTH-1:0]      record_shots;
      logic [POS_WIDTH-1:0]      cycle_shots;
   } cfg_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [POS_WIDTH-1:0] value;
   } rem_type;

   typedef struct packed {
      logic                       daq_out;
      logic                       cam_out;
      logic                       stim_out;
      logic                       block_out;
      logic                       led_daq;
      logic                       led_cam;
      logic                       led_stim;
      logic                       led_block;
      logic [OUT_COUNT_WIDTH-1:0] shot_total;
      logic [OUT_COUNT_WIDTH-1:0] cycles_done;
      logic                       armed;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/csts_cfg.sv =====
// configuration registers of the shot trigger sequencer
`default_nettype none

module csts_cfg (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write,
   input  wire  [csts_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [csts_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output csts_pkg::cfg_type                     cfg,
   output logic                                  cam_write
);
   import csts_pkg::*;

   logic [TIME_CFG_WIDTH-1:0] daq_delay_ff;
   logic [TIME_CFG_WIDTH-1:0] pulse_width_ff;
   logic [POS_WIDTH-1:0]      cam_every_ff;
   logic [POS_WIDTH-1:0]      baseline_ff;
   logic [POS_WIDTH-1:0]      record_ff;
   logic [POS_WIDTH-1:0]      cycle_shots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         daq_delay_ff   <= '0;
         pulse_width_ff <= TIME_CFG_WIDTH'(10);
         cam_every_ff   <= POS_WIDTH'(1);
         baseline_ff    <= '0;
         record_ff      <= '1;
         cycle_shots_ff <= '1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DAQ_DELAY:      daq_delay_ff   <= csr_data[TIME_CFG_WIDTH-1:0];
            CSR_PULSE_WIDTH:    pulse_width_ff <= csr_data[TIME_CFG_WIDTH-1:0];
            CSR_CAM_EVERY:      cam_every_ff   <= csr_data[POS_WIDTH-1:0];
            CSR_BASELINE_SHOTS: baseline_ff    <= csr_data[POS_WIDTH-1:0];
            CSR_RECORD_SHOTS:   record_ff      <= csr_data[POS_WIDTH-1:0];
            CSR_CYCLE_SHOTS:    cycle_shots_ff <= csr_data[POS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // a zero camera period behaves as one
   always_comb begin
      cfg.daq_delay      = daq_delay_ff;
      cfg.pulse_width    = pulse_width_ff;
      cfg.period         = (cam_every_ff == '0) ? POS_WIDTH'(1) : cam_every_ff;
      cfg.baseline_shots = baseline_ff;
      cfg.record_shots   = record_ff;
      cfg.cycle_shots    = cycle_shots_ff;
   end

   // the new period reaches the remainder unit in the following cycle, with the register
   assign cam_write = csr_write && (csr_index == CSR_CAM_EVERY);

endmodule

`default_nettype wire

// ===== src/csts_rem.sv =====
// bit-serial remainder unit that realigns the camera phase after a period change
`default_nettype none

module csts_rem (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire  [csts_pkg::POS_WIDTH-1:0] dividend,
   input  wire  [csts_pkg::POS_WIDTH-1:0] divisor,
   output csts_pkg::rem_type              rem
);
   import csts_pkg::*;

   logic                      busy_ff;
   logic                      done_ff;
   logic                      pending_ff;
   logic [REM_STEP_WIDTH-1:0] step_ff;
   logic [POS_WIDTH-1:0]      num_ff;
   logic [POS_WIDTH-1:0]      rem_ff;
   logic [POS_WIDTH:0]        trial;
   logic [POS_WIDTH-1:0]      rem_in;

   always_comb begin
      trial = {rem_ff, num_ff[POS_WIDTH-1]};
      if (trial >= {1'b0, divisor}) begin
         rem_in = POS_WIDTH'(trial - {1'b0, divisor});
      end else begin
         rem_in = trial[POS_WIDTH-1:0];
      end
   end

   // pending holds the load back so the divisor register holds the new period
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         done_ff    <= 1'b0;
         pending_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            pending_ff <= 1'b1;
            busy_ff    <= 1'b0;
         end else if (pending_ff) begin
            pending_ff <= 1'b0;
            busy_ff    <= 1'b1;
            step_ff    <= '1;
            num_ff     <= dividend;
            rem_ff     <= '0;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            num_ff  <= {num_ff[POS_WIDTH-2:0], 1'b0};
            step_ff <= step_ff - REM_STEP_WIDTH'(1);
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rem.busy  = busy_ff || pending_ff || start;
   assign rem.done  = done_ff;
   assign rem.value = rem_ff;

endmodule

`default_nettype wire

// ===== src/csts_core.sv =====
// sequencer state, single-pass tick update and result register
`default_nettype none

module csts_core #(
   parameter int unsigned COUNT_WIDTH = 32,
   parameter int unsigned TIMER_WIDTH = 24
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             step,
   input  wire  [csts_pkg::KIND_WIDTH-1:0] kind,
   input  wire                             trig_level,
   input  csts_pkg::cfg_type               cfg,
   input  csts_pkg::rem_type               rem,
   output logic [csts_pkg::POS_WIDTH-1:0]  cycle_pos,
   output csts_pkg::rsp_type               rsp
);
   import csts_pkg::*;

   typedef enum logic [1:0] {PH_IDLE, PH_DELAY, PH_PULSE} phase_type;

   localparam logic [POS_WIDTH:0] TIMER_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;

   logic                   arm_ff,   arm_in;
   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] tick_ff,  tick_in;
   logic                   prev_ff,  prev_in;
   logic [POS_WIDTH-1:0]   pos_ff,   pos_in;
   logic [POS_WIDTH-1:0]   camph_ff, camph_in;
   logic [COUNT_WIDTH-1:0] shot_ff,  shot_in;
   logic [COUNT_WIDTH-1:0] cyc_ff,   cyc_in;
   logic [2:0]             pulse_ff, pulse_in;
   logic                   block_ff, block_in;
   logic [3:0]             led_ff,   led_in;
   rsp_type                rsp_ff,   rsp_in;

   logic [TIMER_WIDTH-1:0] delay_load;
   logic [TIMER_WIDTH-1:0] width_load;
   logic [POS_WIDTH-1:0]   delay_ext;
   logic [POS_WIDTH-1:0]   width_ext;
   logic [2:0]             mask;
   logic [63:0]            shot_ext;
   logic [63:0]            cyc_ext;

   // timer loads saturate when the timer is narrower than the register
   always_comb begin
      delay_ext  = POS_WIDTH'(cfg.daq_delay);
      width_ext  = POS_WIDTH'(cfg.pulse_width);
      delay_load = (delay_ext > TIMER_MAX[POS_WIDTH-1:0]) ?
                   TIMER_MAX[TIMER_WIDTH-1:0] : delay_ext[TIMER_WIDTH-1:0];
      width_load = (width_ext > TIMER_MAX[POS_WIDTH-1:0]) ?
                   TIMER_MAX[TIMER_WIDTH-1:0] : width_ext[TIMER_WIDTH-1:0];
   end

   always_comb begin
      arm_in   = arm_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      camph_in = camph_ff;
      shot_in  = shot_ff;
      cyc_in   = cyc_ff;
      pulse_in = pulse_ff;
      block_in = block_ff;
      led_in   = led_ff;
      mask     = {pos_ff == cfg.baseline_shots, camph_ff == '0, 1'b1};

      case (kind)
         KIND_START: begin
            arm_in   = 1'b1;
            phase_in = PH_IDLE;
            tick_in  = '0;
            prev_in  = 1'b0;
            pos_in   = '0;
            camph_in = '0;
            shot_in  = '0;
            cyc_in   = '0;
            pulse_in = '0;
            block_in = 1'b0;
            led_in   = '0;
         end
         KIND_STOP: begin
            arm_in   = 1'b0;
            phase_in = PH_IDLE;
            tick_in  = '0;
            pulse_in = '0;
         end
         KIND_TICK: begin
            prev_in = trig_level;
            if (phase_in == PH_PULSE) begin
               if (tick_in == '0) begin
                  pulse_in = '0;
                  phase_in = PH_IDLE;
               end else begin
                  tick_in = tick_in - TIMER_WIDTH'(1);
               end
            end
            // edges are only taken when nothing is running
            if (phase_in == PH_IDLE && arm_ff && trig_level && !prev_ff) begin
               phase_in = PH_DELAY;
               tick_in  = delay_load;
            end
            if (phase_in == PH_DELAY) begin
               if (tick_in == '0) begin
                  if (pos_ff >= cfg.record_shots) begin
                     block_in = 1'b1;
                     led_in   = BLOCK_MARK;
                     pulse_in = '0;
                     phase_in = PH_IDLE;
                  end else begin
                     block_in = 1'b0;
                     led_in   = {1'b0, mask};
                     if (width_load == '0) begin
                        pulse_in = '0;
                        phase_in = PH_IDLE;
                     end else begin
                        pulse_in = mask;
                        tick_in  = width_load - TIMER_WIDTH'(1);
                        phase_in = PH_PULSE;
                     end
                  end
                  if (pos_ff >= cfg.cycle_shots) begin
                     pos_in   = '0;
                     camph_in = '0;
                     cyc_in   = cyc_ff + COUNT_WIDTH'(1);
                  end else begin
                     pos_in   = pos_ff + POS_WIDTH'(1);
                     camph_in = (camph_ff + POS_WIDTH'(1) == cfg.period) ?
                                '0 : camph_ff + POS_WIDTH'(1);
                  end
                  shot_in = shot_ff + COUNT_WIDTH'(1);
               end else begin
                  tick_in = tick_in - TIMER_WIDTH'(1);
               end
            end
         end
         default: ;
      endcase

      shot_ext = 64'(shot_in);
      cyc_ext  = 64'(cyc_in);
      rsp_in.daq_out     = pulse_in[0];
      rsp_in.cam_out     = pulse_in[1];
      rsp_in.stim_out    = pulse_in[2];
      rsp_in.block_out   = block_in;
      rsp_in.led_daq     = led_in[0];
      rsp_in.led_cam     = led_in[1];
      rsp_in.led_stim    = led_in[2];
      rsp_in.led_block   = led_in[3];
      rsp_in.shot_total  = shot_ext[OUT_COUNT_WIDTH-1:0];
      rsp_in.cycles_done = cyc_ext[OUT_COUNT_WIDTH-1:0];
      rsp_in.armed       = arm_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_ff   <= 1'b0;
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         prev_ff  <= 1'b0;
         pos_ff   <= '0;
         camph_ff <= '0;
         shot_ff  <= '0;
         cyc_ff   <= '0;
         pulse_ff <= '0;
         block_ff <= 1'b0;
         led_ff   <= '0;
      end else begin
         if (step) begin
            arm_ff   <= arm_in;
            phase_ff <= phase_in;
            tick_ff  <= tick_in;
            prev_ff  <= prev_in;
            pos_ff   <= pos_in;
            shot_ff  <= shot_in;
            cyc_ff   <= cyc_in;
            pulse_ff <= pulse_in;
            block_ff <= block_in;
            led_ff   <= led_in;
            rsp_ff   <= rsp_in;
         end
         // realigned camera phase after a period write
         if (rem.done) begin
            camph_ff <= rem.value;
         end else if (step) begin
            camph_ff <= camph_in;
         end
      end
   end

   assign cycle_pos = pos_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== src/cascade_shot_trigger_sequencer.sv =====
// Shot trigger sequencer: ticks with trigger samples in, output levels per tick out.
//
// Input channel req_*: one item per transfer, req_kind selects a tick carrying
// req_trig_level, a stop (disarm, abort delay and pulse) or a start (clear
// counters, marks and block level, then arm). Every item gives exactly one
// result on rsp_*: the trigger output levels, the four LED marks, the shot
// and cycle counters and the armed flag as they stand after that item.
// Each item passes the input register, the single-pass update and the result
// register before rsp_valid. One item can be taken every cycle while neither
// rsp_stall nor a remainder pass holds it back. While rsp_stall holds the
// result, one more item waits in the input register, then req_stall rises.
// Configuration goes through csr_write/csr_index/csr_data while the block is
// idle, a rule the user keeps; the block does not enforce it. A camera period
// write starts a remainder pass to realign the camera phase; req_stall is high
// meanwhile. Reset is synchronous: configuration returns to its defaults, the
// block is disarmed and idle with zero counters, and no result is pending.
`default_nettype none

module cascade_shot_trigger_sequencer #(
   parameter int unsigned COUNT_WIDTH = 32,
   parameter int unsigned TIMER_WIDTH = 24
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [csts_pkg::KIND_WIDTH-1:0]      req_kind,
   input  wire                                  req_trig_level,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic                                 rsp_daq_out,
   output logic                                 rsp_cam_out,
   output logic                                 rsp_stim_out,
   output logic                                 rsp_block_out,
   output logic                                 rsp_led_daq,
   output logic                                 rsp_led_cam,
   output logic                                 rsp_led_stim,
   output logic                                 rsp_led_block,
   output logic [csts_pkg::OUT_COUNT_WIDTH-1:0] rsp_shot_total,
   output logic [csts_pkg::OUT_COUNT_WIDTH-1:0] rsp_cycles_done,
   output logic                                 rsp_armed,
   input  wire                                  csr_write,
   input  wire  [csts_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [csts_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import csts_pkg::*;

   cfg_type              cfg;
   rem_type              rem;
   rsp_type              rsp;
   logic                 cam_write;
   logic [POS_WIDTH-1:0] cycle_pos;

   logic                  in_valid_ff;
   logic [KIND_WIDTH-1:0] in_kind_ff;
   logic                  in_level_ff;
   logic                  out_valid_ff;
   logic                  out_free;
   logic                  step;
   logic                  req_xfer;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = (in_valid_ff && !out_free) || rem.busy;
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_kind_ff  <= req_kind;
         in_level_ff <= req_trig_level;
      end
   end

   csts_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .cam_write (cam_write)
   );

   csts_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (cam_write),
      .dividend (cycle_pos),
      .divisor  (cfg.period),
      .rem      (rem)
   );

   csts_core #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .kind       (in_kind_ff),
      .trig_level (in_level_ff),
      .cfg        (cfg),
      .rem        (rem),
      .cycle_pos  (cycle_pos),
      .rsp        (rsp)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_daq_out     = rsp.daq_out;
   assign rsp_cam_out     = rsp.cam_out;
   assign rsp_stim_out    = rsp.stim_out;
   assign rsp_block_out   = rsp.block_out;
   assign rsp_led_daq     = rsp.led_daq;
   assign rsp_led_cam     = rsp.led_cam;
   assign rsp_led_stim    = rsp.led_stim;
   assign rsp_led_block   = rsp.led_block;
   assign rsp_shot_total  = rsp.shot_total;
   assign rsp_cycles_done = rsp.cycles_done;
   assign rsp_armed       = rsp.armed;

endmodule

`default_nettype wire

// ===== src/csts_chk.sv =====
// port-level checks of the shot trigger sequencer and their binding
`default_nettype none

module csts_chk (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  rsp_valid,
   input wire                                  rsp_stall,
   input wire                                  rsp_daq_out,
   input wire                                  rsp_cam_out,
   input wire                                  rsp_stim_out,
   input wire                                  rsp_block_out,
   input wire                                  rsp_led_daq,
   input wire                                  rsp_led_cam,
   input wire                                  rsp_led_stim,
   input wire                                  rsp_led_block,
   input wire  [csts_pkg::OUT_COUNT_WIDTH-1:0] rsp_shot_total,
   input wire  [csts_pkg::OUT_COUNT_WIDTH-1:0] rsp_cycles_done
);

   // no result is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a held result keeps its counters
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_shot_total)
                                 && $stable(rsp_cycles_done))
      else $error("stalled result changed");

   // a blocked shot never raises the daq pulse output
   a_block_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_block_out && rsp_daq_out))
      else $error("pulse while block output is up");

   // camera and stimulus pulses only ride on a daq pulse
   a_pulse_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_daq_out || (!rsp_cam_out && !rsp_stim_out))
      else $error("camera or stimulus pulse without daq pulse");

   // the block mark excludes the other marks
   a_mark_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_led_block |-> !rsp_led_daq && !rsp_led_cam && !rsp_led_stim)
      else $error("block mark together with shot marks");

endmodule

bind cascade_shot_trigger_sequencer csts_chk u_csts_chk (.*);

`default_nettype wire
